### src/stt_pkg.sv
// Shared types, constants and codes for the software timer table.
package stt_pkg;

  localparam int SLOTS       = 16;
  localparam int IDXW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNTW        = $clog2(SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int PICKW       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [23:0] interval_ticks;
    logic        periodic;
    logic        run_now;
    logic [15:0] cancel_id;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] timer_id;
    logic        table_full;
    logic        last_result;
  } out_t;

  // Oldest expired timer seen so far along the row.
  typedef struct packed {
    logic            found;
    logic [31:0]     diff;
    logic [IDXW-1:0] idx;
    logic [15:0]     id;
  } link_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic        cancel;
    logic [15:0] cancel_id;
    logic [31:0] now;
    logic [23:0] interval;
    logic        periodic;
    logic        run_now;
    logic [15:0] new_id;
  } cmd_t;

endpackage

### src/software_timer_table_top.sv
// Top level of the software timer table: controller and the row of slot cells.
// An add answer sits in the output register next cycle; a cancel gives no answer.
// A tick runs the search wave down the row of SLOTS cells once per expired timer that it
// reports, plus once more for the final search.
// Synchronous active-low reset frees all slots and clears time and the id counter.
module software_timer_table_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  stt_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output stt_pkg::out_t out_data
);

  localparam int SLOTS = stt_pkg::SLOTS;
  localparam int IDXW  = stt_pkg::IDXW;
  localparam int CNTW  = stt_pkg::CNTW;
  localparam int PICKW = stt_pkg::PICKW;

  stt_pkg::state_t state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic [PICKW-1:0] picks_r, picks_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic [15:0]      pend_id_r, pend_id_nxt;
  logic [31:0]      now_r, now_nxt;
  logic [15:0]      next_id_r, next_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  stt_pkg::out_t    out_data_r, out_data_nxt;

  stt_pkg::cmd_t    cmd;
  stt_pkg::link_t   links [SLOTS+1];
  logic [SLOTS-1:0] valid_vec, add_sel, hit_sel;
  logic [IDXW-1:0]  free_idx;
  logic             any_free, acc_in, out_free, scan_done, step, can_pick;
  stt_pkg::op_t     op;

  assign op       = stt_pkg::op_t'(in_data.operation);
  assign in_ready = (state_r == stt_pkg::ST_IDLE) && !out_valid_r;
  assign acc_in   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_vec[i]) begin
        any_free = 1'b1;
        free_idx = IDXW'(i);
      end
    end
  end

  assign scan_done = (state_r == stt_pkg::ST_SCAN) && (cnt_r == CNTW'(SLOTS));
  assign step      = scan_done && (!pend_v_r || out_free);
  assign can_pick  = links[SLOTS].found && (picks_r < PICKW'(stt_pkg::MAX_RESULTS));

  always_comb begin
    cmd.cancel    = acc_in && (op == stt_pkg::OP_CANCEL);
    cmd.cancel_id = in_data.cancel_id;
    cmd.now       = now_r;
    cmd.interval  = in_data.interval_ticks;
    cmd.periodic  = in_data.periodic;
    cmd.run_now   = in_data.run_now;
    cmd.new_id    = next_id_r;
    add_sel = '0;
    hit_sel = '0;
    if (acc_in && op == stt_pkg::OP_ADD && any_free) add_sel[free_idx] = 1'b1;
    if (step && can_pick) hit_sel[links[SLOTS].idx] = 1'b1;
  end

  assign links[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    stt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .add_sel  (add_sel[g]),
      .hit_sel  (hit_sel[g]),
      .slot_idx (IDXW'(g)),
      .link_in  (links[g]),
      .link_out (links[g+1]),
      .valid_out(valid_vec[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stt_pkg::ST_IDLE: if (acc_in && op == stt_pkg::OP_TICK) state_nxt = stt_pkg::ST_SCAN;
      stt_pkg::ST_SCAN: if (step && !can_pick) state_nxt = stt_pkg::ST_IDLE;
      default:          state_nxt = stt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    picks_nxt     = picks_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    now_nxt       = now_r;
    next_id_nxt   = next_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (acc_in) begin
      unique case (op)
        stt_pkg::OP_ADD: begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.result_kind = stt_pkg::KIND_ACK;
          out_data_nxt.timer_id    = any_free ? next_id_r : 16'd0;
          out_data_nxt.table_full  = !any_free;
          out_data_nxt.last_result = 1'b1;
          if (any_free) next_id_nxt = next_id_r + 16'd1;
        end
        stt_pkg::OP_TICK: begin
          now_nxt    = now_r + 32'd1;
          cnt_nxt    = '0;
          picks_nxt  = '0;
          pend_v_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    if (state_r == stt_pkg::ST_SCAN && cnt_r != CNTW'(SLOTS)) cnt_nxt = cnt_r + CNTW'(1);
    if (step) begin
      // The held word goes out only once the next search says whether it is the last.
      if (pend_v_r) begin
        out_valid_nxt            = 1'b1;
        out_data_nxt.result_kind = stt_pkg::KIND_EXPIRE;
        out_data_nxt.timer_id    = pend_id_r;
        out_data_nxt.table_full  = 1'b0;
        out_data_nxt.last_result = !can_pick;
      end
      pend_v_nxt  = can_pick;
      pend_id_nxt = links[SLOTS].id;
      if (can_pick) begin
        picks_nxt = picks_r + PICKW'(1);
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stt_pkg::ST_IDLE;
      cnt_r       <= '0;
      picks_r     <= '0;
      pend_v_r    <= 1'b0;
      now_r       <= '0;
      next_id_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      picks_r     <= picks_nxt;
      pend_v_r    <= pend_v_nxt;
      now_r       <= now_nxt;
      next_id_r   <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/stt_cell.sv
// One timer slot that also passes the running oldest-expired search to its neighbor.
module stt_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stt_pkg::cmd_t           cmd,
  input  logic                    add_sel,
  input  logic                    hit_sel,
  input  logic [stt_pkg::IDXW-1:0] slot_idx,
  input  stt_pkg::link_t          link_in,
  output stt_pkg::link_t          link_out,
  output logic                    valid_out
);

  logic           valid_r, valid_nxt;
  logic [31:0]    deadline_r, deadline_nxt;
  logic [23:0]    interval_r;
  logic           periodic_r;
  logic [15:0]    id_r;
  stt_pkg::link_t link_r, link_nxt;
  logic [31:0]    diff;
  logic           expired;

  assign diff    = deadline_r - cmd.now;
  assign expired = valid_r && diff[31];

  always_comb begin
    link_nxt = link_in;
    if (expired && (!link_in.found || diff < link_in.diff)) begin
      link_nxt.found = 1'b1;
      link_nxt.diff  = diff;
      link_nxt.idx   = slot_idx;
      link_nxt.id    = id_r;
    end
  end

  always_comb begin
    valid_nxt    = valid_r;
    deadline_nxt = deadline_r;
    priority if (add_sel) begin
      valid_nxt    = 1'b1;
      deadline_nxt = cmd.run_now ? cmd.now : cmd.now + {8'd0, cmd.interval};
    end else if (hit_sel) begin
      // Periodic timers reload; a reloaded deadline is never expired in the same tick.
      if (periodic_r) deadline_nxt = cmd.now + {8'd0, interval_r};
      else            valid_nxt    = 1'b0;
    end else if (cmd.cancel && valid_r && id_r == cmd.cancel_id) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      link_r.found <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      link_r.found <= link_nxt.found;
    end
    link_r.diff <= link_nxt.diff;
    link_r.idx  <= link_nxt.idx;
    link_r.id   <= link_nxt.id;
    deadline_r  <= deadline_nxt;
    if (add_sel) begin
      interval_r <= cmd.interval;
      periodic_r <= cmd.periodic;
      id_r       <= cmd.new_id;
    end
  end

  assign link_out  = link_r;
  assign valid_out = valid_r;

endmodule

### sim/testbench.sv
// Self-checking testbench for the software timer table: random and directed timer words.
`timescale 1ns / 100ps

class timer_scoreboard;
  logic          slot_busy [stt_pkg::SLOTS];
  logic [31:0]   slot_due [stt_pkg::SLOTS];
  logic [23:0]   slot_period [stt_pkg::SLOTS];
  logic          slot_reload [stt_pkg::SLOTS];
  logic [15:0]   slot_tag [stt_pkg::SLOTS];
  logic [31:0]   now_ticks;
  logic [15:0]   id_counter;
  stt_pkg::out_t pending_results [$];
  int            errors;
  int            checked;
  int            expiries;
  int            fulls;

  function new();
    foreach (slot_busy[i]) slot_busy[i] = 1'b0;
    now_ticks = '0;
    id_counter = '0;
    errors = 0;
    checked = 0;
    expiries = 0;
    fulls = 0;
  endfunction

  // Work out the results of one accepted input word and update the shadow table.
  function void note_input(stt_pkg::in_t w);
    stt_pkg::out_t r;
    int free_slot;
    int order [$];
    logic taken [stt_pkg::SLOTS];
    int best;
    logic [31:0] best_gap;
    logic [31:0] gap;
    free_slot = -1;
    r = '0;
    case (stt_pkg::op_t'(w.operation))
      stt_pkg::OP_ADD: begin
        foreach (slot_busy[i]) if (!slot_busy[i] && free_slot < 0) free_slot = i;
        r.result_kind = stt_pkg::KIND_ACK;
        r.last_result = 1'b1;
        if (free_slot < 0) begin
          r.table_full = 1'b1;
          fulls++;
        end else begin
          slot_busy[free_slot] = 1'b1;
          slot_period[free_slot] = w.interval_ticks;
          slot_reload[free_slot] = w.periodic;
          slot_tag[free_slot] = id_counter;
          slot_due[free_slot] = w.run_now ? now_ticks : now_ticks + 32'(w.interval_ticks);
          r.timer_id = id_counter;
          id_counter++;
        end
        pending_results.push_back(r);
      end
      stt_pkg::OP_CANCEL: begin
        foreach (slot_busy[i])
          if (slot_busy[i] && slot_tag[i] == w.cancel_id) slot_busy[i] = 1'b0;
      end
      stt_pkg::OP_TICK: begin
        now_ticks++;
        foreach (taken[i]) taken[i] = 1'b0;
        while (order.size() < stt_pkg::MAX_RESULTS) begin
          best = -1;
          best_gap = '0;
          for (int i = 0; i < stt_pkg::SLOTS; i++) begin
            gap = slot_due[i] - now_ticks;
            if (slot_busy[i] && !taken[i] && gap[31] && (best < 0 || gap < best_gap)) begin
              best = i;
              best_gap = gap;
            end
          end
          if (best < 0) break;
          taken[best] = 1'b1;
          order.push_back(best);
        end
        foreach (order[k]) begin
          r = '0;
          r.result_kind = stt_pkg::KIND_EXPIRE;
          r.timer_id = slot_tag[order[k]];
          r.last_result = (k == order.size() - 1);
          pending_results.push_back(r);
          expiries++;
          if (slot_reload[order[k]]) slot_due[order[k]] = now_ticks + 32'(slot_period[order[k]]);
          else slot_busy[order[k]] = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_result(stt_pkg::out_t got);
    stt_pkg::out_t want;
    checked++;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result word %p", $time, got);
      errors++;
      return;
    end
    want = pending_results.pop_front();
    if (got.result_kind !== want.result_kind)
      $display("%0t: result_kind expected %0d actual %0d", $time, want.result_kind, got.result_kind);
    if (got.timer_id !== want.timer_id)
      $display("%0t: timer_id expected %0d actual %0d", $time, want.timer_id, got.timer_id);
    if (got.table_full !== want.table_full)
      $display("%0t: table_full expected %0d actual %0d", $time, want.table_full, got.table_full);
    if (got.last_result !== want.last_result)
      $display("%0t: last_result expected %0d actual %0d", $time, want.last_result, got.last_result);
    if (got !== want) errors++;
  endfunction
endclass

module testbench;
  localparam int WATCHDOG_LIMIT = 20000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  stt_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  stt_pkg::out_t out_data;

  int    send_idle_pct = 0;
  int    stall_pct = 0;
  int    hold_off = 0;
  int    idle_cycles = 0;
  bit    done = 1'b0;

  timer_scoreboard board;

  software_timer_table_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !done) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Valid stays high after a word is taken until the next word or an idle cycle replaces it.
  task automatic send_word(stt_pkg::in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (board.pending_results.size() != 0 && guard < WATCHDOG_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (4 * (stt_pkg::SLOTS + 1) * (stt_pkg::MAX_RESULTS + 1)) @(negedge clk);
  endtask

  function automatic stt_pkg::in_t make_add(logic [23:0] ivl, logic per, logic rn);
    stt_pkg::in_t w;
    w = '0;
    w.operation = stt_pkg::OP_ADD;
    w.interval_ticks = ivl;
    w.periodic = per;
    w.run_now = rn;
    w.cancel_id = 16'($urandom);
    return w;
  endfunction

  function automatic stt_pkg::in_t make_op(stt_pkg::op_t op, logic [15:0] cid);
    stt_pkg::in_t w;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    w = raw[$bits(stt_pkg::in_t)-1:0];
    w.operation = op;
    w.cancel_id = cid;
    return w;
  endfunction

  function automatic stt_pkg::in_t random_word();
    int pick;
    logic [23:0] ivl;
    pick = $urandom_range(99);
    if ($urandom_range(9) == 0) ivl = 24'($urandom);
    else ivl = 24'($urandom_range(6));
    if (pick < 40)
      return make_add(ivl, 1'($urandom_range(1)), $urandom_range(3) == 0);
    if (pick < 50)
      return make_op(stt_pkg::OP_CANCEL, ($urandom_range(4) == 0) ? 16'($urandom)
                     : board.id_counter - 16'($urandom_range(1, 20)));
    if (pick < 97) return make_op(stt_pkg::OP_TICK, 16'($urandom));
    return make_op(stt_pkg::OP_NONE, 16'($urandom));
  endfunction

  initial begin
    board = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: extremes, full table, cancel, mass expiry, unused code.
    send_word(make_add(24'hFFFFFF, 1'b0, 1'b0));
    send_word(make_add(24'd0, 1'b1, 1'b0));
    send_word(make_add(24'd3, 1'b1, 1'b1));
    send_word(make_op(stt_pkg::OP_CANCEL, 16'd0));
    send_word(make_op(stt_pkg::OP_CANCEL, 16'hFFFF));
    send_word(make_op(stt_pkg::OP_TICK, 16'd0));
    send_word(make_op(stt_pkg::OP_NONE, 16'hFFFF));
    for (int i = 0; i < stt_pkg::SLOTS; i++) send_word(make_add(24'd0, i[0], 1'b1));
    send_word(make_op(stt_pkg::OP_TICK, 16'd0));
    send_word(make_op(stt_pkg::OP_TICK, 16'd0));

    // Sender pause until everything has come out.
    drain();

    // Long receiver hold-off while words keep arriving.
    hold_off = 300;
    for (int i = 0; i < 20; i++) send_word(random_word());
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      for (int i = 0; i < 75; i++) send_word(random_word());
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    done = 1'b1;

    $display("Covered adds, cancels, ticks and ignored words; %0d results checked,",
             board.checked);
    $display("including %0d expiries and %0d full-table answers.", board.expiries,
             board.fulls);
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
